// ===== sv/xcfp_pkg.sv =====
`default_nettype none
package xcfp_pkg;

   localparam logic [7:0] FLAG_START = 8'h5A;
   localparam logic [7:0] FLAG_END   = 8'hCA;

   localparam int LEN_W = 6;
   localparam logic [LEN_W-1:0] FRAME_OVERHEAD = 6'd10;
   localparam logic [LEN_W-1:0] CSR_RESET = 6'd32;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_START = 3'd1;
   localparam logic [2:0] ST_TOO_LONG  = 3'd2;
   localparam logic [2:0] ST_BAD_CHECK = 3'd3;
   localparam logic [2:0] ST_BAD_END   = 3'd4;

   typedef struct packed {
      logic [15:0]      msg;
      logic [7:0]       node;
      logic [7:0]       dev;
      logic [7:0]       cmd;
      logic [7:0]       ack;
      logic [LEN_W-1:0] len;
   } hdr_type;

   // parser -> emitter
   typedef struct packed {
      logic       start;
      logic       err;
      logic [2:0] status;
   } emit_cmd_type;

   // emitter -> parser
   typedef struct packed {
      logic busy;
      logic room;
   } emit_stat_type;

endpackage
`default_nettype wire

// ===== sv/xcfp_if.sv =====
`default_nettype none
interface xcfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] message_number;
   logic [7:0]  node_kind;
   logic [7:0]  device_kind;
   logic [7:0]  command_code;
   logic [7:0]  ack_code;
   logic [5:0]  payload_length;
   logic [4:0]  payload_index;
   logic [7:0]  payload_byte;
   logic [5:0]  frame_length;
   logic        last;

   modport source (output valid, input ready, output status, output message_number,
                   output node_kind, output device_kind, output command_code,
                   output ack_code, output payload_length, output payload_index,
                   output payload_byte, output frame_length, output last);
   modport sink (input valid, output ready, input status, input message_number,
                 input node_kind, input device_kind, input command_code,
                 input ack_code, input payload_length, input payload_index,
                 input payload_byte, input frame_length, input last);
endinterface
`default_nettype wire

// ===== sv/xcfp_parse.sv =====
`default_nettype none
module xcfp_parse
   import xcfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 32,
   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   xcfp_req_if.sink               req_ch,
   input  wire logic              csr_we,
   input  wire logic [LEN_W-1:0]  csr_wdata,
   input  wire emit_stat_type     stat,
   output emit_cmd_type           cmd,
   output hdr_type                hdr,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [7:0]             wr_data
);

   localparam logic [3:0] PH_WAIT   = 4'd0;
   localparam logic [3:0] PH_MSG_HI = 4'd1;
   localparam logic [3:0] PH_MSG_LO = 4'd2;
   localparam logic [3:0] PH_NODE   = 4'd3;
   localparam logic [3:0] PH_DEV    = 4'd4;
   localparam logic [3:0] PH_CMD    = 4'd5;
   localparam logic [3:0] PH_ACK    = 4'd6;
   localparam logic [3:0] PH_LEN    = 4'd7;
   localparam logic [3:0] PH_DATA   = 4'd8;
   localparam logic [3:0] PH_CHECK  = 4'd9;
   localparam logic [3:0] PH_END    = 4'd10;

   localparam logic [7:0] MaxPay8 = 8'(MAX_PAYLOAD);

   logic [3:0]       phase_ff, phase_in;
   logic [7:0]       xor_ff, xor_in;
   hdr_type          hdr_ff, hdr_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] maxlen_ff;
   logic             quiet;
   logic             take;
   logic [7:0]       b;
   logic [7:0]       limit;
   logic [LEN_W-1:0] count_nx;

   // phases that never produce a result need no room at the output
   assign quiet = (phase_ff inside {[PH_MSG_HI:PH_ACK], PH_DATA});
   assign req_ch.ready = !stat.busy && (quiet || stat.room);
   assign take = req_ch.valid && req_ch.ready;
   assign b = req_ch.rx_byte;
   assign limit = ({2'b00, maxlen_ff} > MaxPay8) ? MaxPay8 : {2'b00, maxlen_ff};
   assign count_nx = count_ff + 1'b1;

   assign hdr = hdr_ff;
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign wr_data = b;

   always_comb begin
      phase_in = phase_ff;
      xor_in = xor_ff;
      hdr_in = hdr_ff;
      count_in = count_ff;
      cmd = '0;
      wr_en = 1'b0;
      if (take) begin
         case (phase_ff)
            PH_MSG_HI: begin
               xor_in = xor_ff ^ b;
               hdr_in = '0;
               hdr_in.msg[15:8] = b;
               phase_in = PH_MSG_LO;
            end
            PH_MSG_LO: begin
               xor_in = xor_ff ^ b;
               hdr_in.msg[7:0] = b;
               phase_in = PH_NODE;
            end
            PH_NODE: begin
               xor_in = xor_ff ^ b;
               hdr_in.node = b;
               phase_in = PH_DEV;
            end
            PH_DEV: begin
               xor_in = xor_ff ^ b;
               hdr_in.dev = b;
               phase_in = PH_CMD;
            end
            PH_CMD: begin
               xor_in = xor_ff ^ b;
               hdr_in.cmd = b;
               phase_in = PH_ACK;
            end
            PH_ACK: begin
               xor_in = xor_ff ^ b;
               hdr_in.ack = b;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (b > limit) begin
                  cmd.err = 1'b1;
                  cmd.status = ST_TOO_LONG;
                  phase_in = PH_WAIT;
                  xor_in = '0;
                  count_in = '0;
               end else begin
                  xor_in = xor_ff ^ b;
                  hdr_in.len = b[LEN_W-1:0];
                  count_in = '0;
                  phase_in = (b == 8'd0) ? PH_CHECK : PH_DATA;
               end
            end
            PH_DATA: begin
               xor_in = xor_ff ^ b;
               wr_en = 1'b1;
               count_in = count_nx;
               if (count_nx >= hdr_ff.len) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               if (b != xor_ff) begin
                  cmd.err = 1'b1;
                  cmd.status = ST_BAD_CHECK;
                  phase_in = PH_WAIT;
                  xor_in = '0;
                  count_in = '0;
               end else begin
                  phase_in = PH_END;
               end
            end
            PH_END: begin
               if (b != FLAG_END) begin
                  cmd.err = 1'b1;
                  cmd.status = ST_BAD_END;
               end else begin
                  cmd.start = 1'b1;
               end
               phase_in = PH_WAIT;
               xor_in = '0;
               count_in = '0;
            end
            default: begin
               if (b != FLAG_START) begin
                  cmd.err = 1'b1;
                  cmd.status = ST_BAD_START;
                  phase_in = PH_WAIT;
                  xor_in = '0;
                  count_in = '0;
               end else begin
                  xor_in = b;
                  hdr_in = '0;
                  count_in = '0;
                  phase_in = PH_MSG_HI;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         xor_ff <= '0;
         hdr_ff <= '0;
         count_ff <= '0;
         maxlen_ff <= CSR_RESET;
      end else begin
         phase_ff <= phase_in;
         xor_ff <= xor_in;
         hdr_ff <= hdr_in;
         count_ff <= count_in;
         if (csr_we) begin
            maxlen_ff <= csr_wdata;
         end
      end
   end

endmodule
`default_nettype wire

// ===== sv/xcfp_emit.sv =====
`default_nettype none
module xcfp_emit
   import xcfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 32,
   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire emit_cmd_type      cmd,
   input  wire hdr_type           hdr,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   output emit_stat_type          stat,
   xcfp_rsp_if.source             rsp_ch
);

   logic [7:0]       mem [MAX_PAYLOAD];
   logic [7:0]       mem_q_ff;

   logic             emit_ff;
   logic [LEN_W-1:0] k_ff;
   logic [LEN_W-1:0] n_ff;
   logic             s1_ff;
   logic [LEN_W-1:0] k1_ff;
   logic             last1_ff;

   logic             out_valid_ff;
   logic [2:0]       out_status_ff;
   hdr_type          out_hdr_ff;
   logic [4:0]       out_index_ff;
   logic [7:0]       out_byte_ff;
   logic [LEN_W-1:0] out_flen_ff;
   logic             out_last_ff;

   logic             room;
   logic             s1_move;
   logic             rd_en;
   logic             k_last;

   assign room = !out_valid_ff || rsp_ch.ready;
   assign s1_move = s1_ff && room;
   assign rd_en = emit_ff && (!s1_ff || s1_move);
   assign k_last = (k_ff == n_ff - 1'b1);

   assign stat.busy = emit_ff || s1_ff;
   assign stat.room = room;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[k_ff[ADDR_W-1:0]];
      end
   end

   // read sequencer: one payload entry per cycle while the output keeps up
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
         s1_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            emit_ff <= 1'b1;
         end else if (rd_en && k_last) begin
            emit_ff <= 1'b0;
         end
         if (rd_en) begin
            s1_ff <= 1'b1;
         end else if (s1_move) begin
            s1_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         k_ff <= '0;
         n_ff <= (hdr.len == '0) ? LEN_W'(1) : hdr.len;
      end else if (rd_en) begin
         k_ff <= k_ff + 1'b1;
      end
      if (rd_en) begin
         k1_ff <= k_ff;
         last1_ff <= k_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.err || s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.err) begin
         out_status_ff <= cmd.status;
         out_hdr_ff <= '0;
         out_index_ff <= '0;
         out_byte_ff <= '0;
         out_flen_ff <= '0;
         out_last_ff <= 1'b1;
      end else if (s1_move) begin
         out_status_ff <= ST_OK;
         out_hdr_ff <= hdr;
         out_index_ff <= k1_ff[4:0];
         out_byte_ff <= (hdr.len == '0) ? 8'd0 : mem_q_ff;
         out_flen_ff <= hdr.len + FRAME_OVERHEAD;
         out_last_ff <= last1_ff;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.status = out_status_ff;
   assign rsp_ch.message_number = out_hdr_ff.msg;
   assign rsp_ch.node_kind = out_hdr_ff.node;
   assign rsp_ch.device_kind = out_hdr_ff.dev;
   assign rsp_ch.command_code = out_hdr_ff.cmd;
   assign rsp_ch.ack_code = out_hdr_ff.ack;
   assign rsp_ch.payload_length = out_hdr_ff.len;
   assign rsp_ch.payload_index = out_index_ff;
   assign rsp_ch.payload_byte = out_byte_ff;
   assign rsp_ch.frame_length = out_flen_ff;
   assign rsp_ch.last = out_last_ff;

endmodule
`default_nettype wire

// ===== sv/xor_checked_frame_parser.sv =====
// Channel   Dir  Transfer when      Payload
// req_ch    in   valid & ready      rx_byte
// rsp_ch    out  valid & ready      status, header fields, payload_index/_byte, last
// csr_*     in   csr_we             csr_wdata -> max_payload_len
//
// Header, payload and check bytes are taken one per cycle.
// A good end flag starts a readout of the payload memory: each byte is read
// into a register and then into the output register, one result per cycle
// while rsp_ready stays high; req_ready is low for the whole readout.
// Errors give one result straight from the parser.
// Reset is synchronous; it clears the parser phase, the readout and the output.
// A stalled output holds; bytes that can raise a result wait for space.
`default_nettype none
module xor_checked_frame_parser
   import xcfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   xcfp_req_if.sink              req_ch,
   xcfp_rsp_if.source            rsp_ch,
   input  wire logic             csr_we,
   input  wire logic [LEN_W-1:0] csr_wdata
);

   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   emit_cmd_type      cmd;
   emit_stat_type     stat;
   hdr_type           hdr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   xcfp_parse #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parse (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .cmd       (cmd),
      .hdr       (hdr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   xcfp_emit #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_emit (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .hdr     (hdr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .stat    (stat),
      .rsp_ch  (rsp_ch)
   );

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != ST_OK |-> rsp_ch.last)
      else $error("error result without last");

   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> !req_ch.ready)
      else $error("input accepted during readout");

   a_readout_after_end: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> req_ch.valid && req_ch.ready && req_ch.rx_byte == FLAG_END)
      else $error("readout started without an end flag transfer");

   a_no_double_load: assert property (@(posedge clock) disable iff (reset)
      cmd.err |-> !stat.busy && stat.room)
      else $error("error result with no output space");

endmodule
`default_nettype wire
